// ===== rtl/core/priority_output_command_arbiter_defines.svh =====
// Assertion helpers for the arbiter, which checks its own logic.
`ifndef PRIORITY_OUTPUT_COMMAND_ARBITER_DEFINES_SVH
`define PRIORITY_OUTPUT_COMMAND_ARBITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define POCA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define POCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/poca_pkg.sv =====
package poca_pkg;

   localparam int OUT_MAX = 16;
   localparam int OUT_W = 4;

   localparam logic [2:0] FUNC_SUBMIT = 3'd0;
   localparam logic [2:0] FUNC_RELINQUISH = 3'd1;
   localparam logic [2:0] FUNC_EXPIRE = 3'd2;
   localparam logic [2:0] FUNC_QUERY = 3'd3;
   localparam logic [2:0] FUNC_OBSERVE = 3'd4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [4:0] PRIO_MAX = 5'd16;
   localparam logic [63:0] TIME_NEVER = 64'h8000_0000_0000_0000;

   // Stored part of a command slot; the used flag lives in flip-flops.
   typedef struct packed {
      logic        val;
      logic [15:0] src;
      logic [4:0]  prio;
      logic [3:0]  out;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic [2:0]         func;
      logic [4:0]         output_index;
      logic [4:0]         priority_req;
      logic [15:0]        src_id;
      logic [15:0]        corr_id;
      logic               cmd_value;
      logic signed [63:0] issue_ms;
      logic signed [63:0] expiry_ms;
      logic signed [63:0] now_ms;
      logic [15:0]        observed_outputs;
   } req_type;

endpackage

// ===== rtl/core/poca_if.sv =====
interface poca_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic [4:0]         output_index;
   logic [4:0]         priority_req;
   logic [15:0]        src_id;
   logic [15:0]        corr_id;
   logic               cmd_value;
   logic signed [63:0] issue_ms;
   logic signed [63:0] expiry_ms;
   logic signed [63:0] now_ms;
   logic [15:0]        observed_outputs;

   modport source (output valid, func, output_index, priority_req, src_id, corr_id,
      cmd_value, issue_ms, expiry_ms, now_ms, observed_outputs, input ready);
   modport sink (input valid, func, output_index, priority_req, src_id, corr_id,
      cmd_value, issue_ms, expiry_ms, now_ms, observed_outputs, output ready);
endinterface

interface poca_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        is_effective;
   logic [15:0] drive_outputs;
   logic        drive_write;
   logic [31:0] rejected_count;
   logic [31:0] accepted_count;
   logic [31:0] relinquished_count;
   logic [31:0] expired_count;

   modport source (output valid, status, is_effective, drive_outputs, drive_write,
      rejected_count, accepted_count, relinquished_count, expired_count, input ready);
   modport sink (input valid, status, is_effective, drive_outputs, drive_write,
      rejected_count, accepted_count, relinquished_count, expired_count, output ready);
endinterface

// ===== rtl/core/poca_ram.sv =====
module poca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/core/priority_output_command_arbiter.sv =====
// Channel   Port    Direction  Carries
// request   req_ch  in         one operation (submit, relinquish, expiry, query, observe)
// response  rsp_ch  out        status, query answer, output bitmap, write strobe, counters
//
// A submit, relinquish or expiry that changes the table runs, from one request transfer to the
// next, a check step, a modifying pass and a winner pass over all SLOT_COUNT slots each, a
// finish step and the idle state that takes the next request. Query and observe skip the
// modifying pass; a full table, a relinquish that finds nothing and an expiry that frees
// nothing skip the winner pass. Requests rejected at the check go straight to the finish
// step. Each pass reads one slot per cycle from the slot memories. Reset is synchronous and
// clears every slot at once through the per-slot used flags. A stalled response blocks only
// the finish of the following operation; its scan still runs.
`include "priority_output_command_arbiter_defines.svh"

module priority_output_command_arbiter #(
   parameter int OUTPUT_COUNT = 16,
   parameter int SLOT_COUNT = 16
) (
   input logic         clock,
   input logic         reset,
   poca_req_if.sink    req_ch,
   poca_rsp_if.source  rsp_ch
);
   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam logic [CW-1:0] SCAN_END = CW'(SLOT_COUNT);
   localparam logic [15:0] OUT_MASK = 16'((32'd1 << OUTPUT_COUNT) - 32'd1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MODIFY = 3'd2;
   localparam logic [2:0] S_WINNER = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]             state_ff, state_in;
   poca_pkg::req_type      cur_ff, cur_in;
   logic [SLOT_COUNT-1:0]  used_ff, used_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [AW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   match_ff, match_in;
   logic [AW-1:0]          match_idx_ff, match_idx_in;
   logic                   free_ff, free_in;
   logic [AW-1:0]          free_idx_ff, free_idx_in;
   logic                   any_ff, any_in;
   logic [15:0]            has_ff, has_in;
   logic [4:0]             best_prio_ff [poca_pkg::OUT_MAX];
   logic [4:0]             best_prio_in [poca_pkg::OUT_MAX];
   logic [15:0]            best_val_ff, best_val_in;
   logic [15:0]            q_src_ff, q_src_in;
   logic [15:0]            base_ff, base_in;
   logic [15:0]            cmd_ff, cmd_in;
   logic                   cv_ff, cv_in;
   logic [31:0]            rej_ff, rej_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            rel_ff, rel_in;
   logic [31:0]            exp_ff, exp_in;
   logic [1:0]             status_ff, status_in;
   logic                   eff_ff, eff_in;
   logic                   wrote_ff, wrote_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_eff_ff, rsp_eff_in;
   logic [15:0]            rsp_drive_ff, rsp_drive_in;
   logic                   rsp_write_ff, rsp_write_in;
   logic [31:0]            rsp_rej_ff, rsp_rej_in;
   logic [31:0]            rsp_acc_ff, rsp_acc_in;
   logic [31:0]            rsp_rel_ff, rsp_rel_in;
   logic [31:0]            rsp_exp_ff, rsp_exp_in;

   // Slot memory ports.
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   poca_pkg::slot_type     info_wdata, info_rd;
   logic [63:0]            exp_rd;

   logic                   req_accept;
   logic                   out_ok;
   logic                   submit_bad;
   logic                   relinq_bad;
   logic [15:0]            eff_bm;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept = req_ch.valid && req_ch.ready;

   poca_ram #(.WIDTH(poca_pkg::SLOT_W), .DEPTH(SLOT_COUNT)) u_info_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (info_wdata),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (info_rd)
   );

   poca_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_expiry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (cur_ff.expiry_ms),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (exp_rd)
   );

   assign ram_waddr = match_ff ? match_idx_ff : free_idx_ff;
   assign info_wdata = '{val: cur_ff.cmd_value, src: cur_ff.src_id,
                         prio: cur_ff.priority_req, out: cur_ff.output_index[3:0]};

   assign out_ok = (32'(cur_ff.output_index) < 32'(OUTPUT_COUNT));
   assign submit_bad = !out_ok || (cur_ff.priority_req == 5'd0) ||
                       (cur_ff.priority_req > poca_pkg::PRIO_MAX) ||
                       (cur_ff.src_id == 16'd0) || (cur_ff.corr_id == 16'd0) ||
                       (cur_ff.issue_ms > cur_ff.now_ms) ||
                       ((cur_ff.expiry_ms != poca_pkg::TIME_NEVER) &&
                        (cur_ff.expiry_ms <= cur_ff.now_ms));
   assign relinq_bad = !out_ok || (cur_ff.now_ms == poca_pkg::TIME_NEVER);

   // Effective bitmap: the baseline with every commanded output overridden by its winner.
   always_comb begin
      for (int o = 0; o < poca_pkg::OUT_MAX; o++) begin
         eff_bm[o] = has_ff[o] ? best_val_ff[o] : base_ff[o];
      end
   end

   always_comb begin
      logic scan_done;
      logic [3:0] so;
      state_in = state_ff;
      cur_in = cur_ff;
      used_in = used_ff;
      cnt_in = cnt_ff;
      rd_valid_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      match_in = match_ff;
      match_idx_in = match_idx_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      any_in = any_ff;
      has_in = has_ff;
      best_prio_in = best_prio_ff;
      best_val_in = best_val_ff;
      q_src_in = q_src_ff;
      base_in = base_ff;
      cmd_in = cmd_ff;
      cv_in = cv_ff;
      rej_in = rej_ff;
      acc_in = acc_ff;
      rel_in = rel_ff;
      exp_in = exp_ff;
      status_in = status_ff;
      eff_in = eff_ff;
      wrote_in = wrote_ff;
      ram_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_eff_in = rsp_eff_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_write_in = rsp_write_ff;
      rsp_rej_in = rsp_rej_ff;
      rsp_acc_in = rsp_acc_ff;
      rsp_rel_in = rsp_rel_ff;
      rsp_exp_in = rsp_exp_ff;
      scan_done = (cnt_ff == SCAN_END) && !rd_valid_ff;
      so = info_rd.out;

      // Both passes issue one read per cycle; the data returns in the next cycle.
      if ((state_ff == S_MODIFY || state_ff == S_WINNER) && cnt_ff != SCAN_END) begin
         rd_valid_in = 1'b1;
         rd_idx_in = cnt_ff[AW-1:0];
         cnt_in = cnt_ff + CW'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cur_in = '{func: req_ch.func, output_index: req_ch.output_index,
                          priority_req: req_ch.priority_req, src_id: req_ch.src_id,
                          corr_id: req_ch.corr_id,
                          cmd_value: req_ch.cmd_value, issue_ms: req_ch.issue_ms,
                          expiry_ms: req_ch.expiry_ms, now_ms: req_ch.now_ms,
                          observed_outputs: req_ch.observed_outputs};
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = poca_pkg::STATUS_OK;
            eff_in = 1'b0;
            wrote_in = 1'b0;
            match_in = 1'b0;
            free_in = 1'b0;
            any_in = 1'b0;
            has_in = '0;
            cnt_in = '0;
            case (cur_ff.func)
               poca_pkg::FUNC_SUBMIT: begin
                  if (submit_bad) begin
                     status_in = poca_pkg::STATUS_INVALID;
                     rej_in = rej_ff + 32'd1;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_MODIFY;
                  end
               end
               poca_pkg::FUNC_RELINQUISH: begin
                  if (relinq_bad) begin
                     status_in = poca_pkg::STATUS_INVALID;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_MODIFY;
                  end
               end
               poca_pkg::FUNC_EXPIRE: state_in = S_MODIFY;
               poca_pkg::FUNC_QUERY, poca_pkg::FUNC_OBSERVE: state_in = S_WINNER;
               default: begin
                  status_in = poca_pkg::STATUS_INVALID;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_MODIFY: begin
            if (rd_valid_ff) begin
               case (cur_ff.func)
                  poca_pkg::FUNC_SUBMIT: begin
                     if (used_ff[rd_idx_ff] && so == cur_ff.output_index[3:0] &&
                         info_rd.prio == cur_ff.priority_req &&
                         info_rd.src == cur_ff.src_id && !match_ff) begin
                        match_in = 1'b1;
                        match_idx_in = rd_idx_ff;
                     end
                     if (!used_ff[rd_idx_ff] && !free_ff) begin
                        free_in = 1'b1;
                        free_idx_in = rd_idx_ff;
                     end
                  end
                  poca_pkg::FUNC_RELINQUISH: begin
                     if (used_ff[rd_idx_ff] && so == cur_ff.output_index[3:0] &&
                         info_rd.src == cur_ff.src_id) begin
                        used_in[rd_idx_ff] = 1'b0;
                        any_in = 1'b1;
                     end
                  end
                  default: begin
                     if (used_ff[rd_idx_ff] && exp_rd != poca_pkg::TIME_NEVER &&
                         cur_ff.now_ms >= $signed(exp_rd)) begin
                        used_in[rd_idx_ff] = 1'b0;
                        any_in = 1'b1;
                        exp_in = exp_ff + 32'd1;
                     end
                  end
               endcase
            end else if (scan_done) begin
               cnt_in = '0;
               state_in = S_WINNER;
               case (cur_ff.func)
                  poca_pkg::FUNC_SUBMIT: begin
                     if (match_ff || free_ff) begin
                        ram_we = 1'b1;
                        used_in[ram_waddr] = 1'b1;
                        acc_in = acc_ff + 32'd1;
                     end else begin
                        status_in = poca_pkg::STATUS_FULL;
                        rej_in = rej_ff + 32'd1;
                        state_in = S_FINISH;
                     end
                  end
                  poca_pkg::FUNC_RELINQUISH: begin
                     if (any_ff) begin
                        rel_in = rel_ff + 32'd1;
                     end else begin
                        status_in = poca_pkg::STATUS_NOT_FOUND;
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     if (!any_ff) begin
                        state_in = S_FINISH;
                     end
                  end
               endcase
            end
         end
         S_WINNER: begin
            if (rd_valid_ff) begin
               // Strictly lower priority replaces, so the earlier slot keeps a tie.
               if (used_ff[rd_idx_ff] && (!has_ff[so] || info_rd.prio < best_prio_ff[so])) begin
                  has_in[so] = 1'b1;
                  best_prio_in[so] = info_rd.prio;
                  best_val_in[so] = info_rd.val;
                  if (so == cur_ff.output_index[3:0]) begin
                     q_src_in = info_rd.src;
                  end
               end
            end else if (scan_done) begin
               state_in = S_FINISH;
               case (cur_ff.func)
                  poca_pkg::FUNC_QUERY: begin
                     eff_in = out_ok && has_ff[cur_ff.output_index[3:0]] &&
                              (q_src_ff == cur_ff.src_id);
                  end
                  poca_pkg::FUNC_OBSERVE: begin
                     if (!cv_ff) begin
                        base_in = cur_ff.observed_outputs;
                        cmd_in = cur_ff.observed_outputs;
                        cv_in = 1'b1;
                     end else begin
                        base_in = (base_ff & ~(OUT_MASK & ~has_ff)) |
                                  (cur_ff.observed_outputs & OUT_MASK & ~has_ff);
                     end
                  end
                  default: begin
                     if (!(cv_ff && eff_bm == cmd_ff)) begin
                        cmd_in = eff_bm;
                        cv_in = 1'b1;
                        wrote_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_eff_in = eff_ff;
               rsp_drive_in = cmd_ff;
               rsp_write_in = wrote_ff;
               rsp_rej_in = rej_ff;
               rsp_acc_in = acc_ff;
               rsp_rel_in = rel_ff;
               rsp_exp_in = exp_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         cnt_ff <= '0;
         rd_valid_ff <= 1'b0;
         base_ff <= '0;
         cmd_ff <= '0;
         cv_ff <= 1'b0;
         rej_ff <= '0;
         acc_ff <= '0;
         rel_ff <= '0;
         exp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         cnt_ff <= cnt_in;
         rd_valid_ff <= rd_valid_in;
         base_ff <= base_in;
         cmd_ff <= cmd_in;
         cv_ff <= cv_in;
         rej_ff <= rej_in;
         acc_ff <= acc_in;
         rel_ff <= rel_in;
         exp_ff <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rd_idx_ff <= rd_idx_in;
      match_ff <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff <= free_in;
      free_idx_ff <= free_idx_in;
      any_ff <= any_in;
      has_ff <= has_in;
      best_prio_ff <= best_prio_in;
      best_val_ff <= best_val_in;
      q_src_ff <= q_src_in;
      status_ff <= status_in;
      eff_ff <= eff_in;
      wrote_ff <= wrote_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eff_ff <= rsp_eff_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_write_ff <= rsp_write_in;
      rsp_rej_ff <= rsp_rej_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_rel_ff <= rsp_rel_in;
      rsp_exp_ff <= rsp_exp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.is_effective = rsp_eff_ff;
   assign rsp_ch.drive_outputs = rsp_drive_ff;
   assign rsp_ch.drive_write = rsp_write_ff;
   assign rsp_ch.rejected_count = rsp_rej_ff;
   assign rsp_ch.accepted_count = rsp_acc_ff;
   assign rsp_ch.relinquished_count = rsp_rel_ff;
   assign rsp_ch.expired_count = rsp_exp_ff;

   // A write strobe always leaves a valid commanded bitmap behind it.
   `POCA_ASSERT_NOW(a_write_needs_valid, clock, reset, rsp_valid_ff && rsp_write_ff, cv_ff, "drive write without valid bitmap")
   // Returned read data belongs to one of the two scan passes.
   `POCA_ASSERT_NOW(a_read_in_scan, clock, reset, rd_valid_ff, state_ff == S_MODIFY || state_ff == S_WINNER, "slot read outside a scan")
   // A request transfer always starts the check step.
   `POCA_ASSERT_NEXT(a_accept_checks, clock, reset, req_accept, state_ff == S_CHECK, "accepted request not checked")
endmodule
